// ===== rtl/sustain_pedal_controller_core_defines.svh =====
// Assertion macros used by the note unit of the sustain pedal controller RTL.
`ifndef SUSTAIN_PEDAL_CONTROLLER_CORE_DEFINES_SVH
`define SUSTAIN_PEDAL_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// Shared types, codes, constants and helper functions of the sustain pedal controller.
package spc_pkg;

	// Default number of notes kept in the sustain bitmap
	localparam int SPC_NOTE_COUNT = 128;

	// Event kinds
	localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
	localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
	localparam logic [1:0] FUNC_PEDAL    = 2'd2;

	// Pedal modes (the unused code behaves as binary)
	localparam logic [1:0] MODE_AUTO       = 2'd0;
	localparam logic [1:0] MODE_BINARY     = 2'd1;
	localparam logic [1:0] MODE_CONTINUOUS = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_SENSE_MODE       = 2'd0;
	localparam logic [1:0] REG_BINARY_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_NOISE_ENABLE     = 2'd2;

	// Hold levels and pedal thresholds
	localparam logic [6:0] CONT_ON     = 7'd115;
	localparam logic [6:0] CONT_OFF    = 7'd105;
	localparam logic [7:0] BIN_HYST    = 8'd3;
	localparam logic [7:0] AUTO_SPREAD = 8'd8;
	localparam logic [6:0] NOISE_MOVE  = 7'd10;
	localparam logic [6:0] PEDAL_MAX   = 7'd127;
	localparam logic [31:0] SEED_FILL  = 32'h9E37_79B9;

	// Register reset values
	localparam logic [1:0] RST_SENSE_MODE       = MODE_AUTO;
	localparam logic [6:0] RST_BINARY_THRESHOLD = 7'd64;
	localparam logic       RST_NOISE_ENABLE     = 1'b1;

	// Pedal unit to note bitmap
	typedef struct packed {
		logic hold_test; // note-off would be held
		logic drop;      // pedal event drops hold
	} spc_evt_t;

	// Pedal unit results for one event
	typedef struct packed {
		logic        hold;
		logic        cont;
		logic [6:0]  last_pedal;
		logic        fire;
		logic        down;
		logic [6:0]  intensity;
		logic [31:0] seed;
	} spc_pedal_res_t;

	// One result beat, lowest field last
	typedef struct packed {
		logic [31:0] noise_seed;
		logic [6:0]  noise_intensity;
		logic        noise_down;
		logic        noise_fire;
		logic [6:0]  damper_level;
		logic [6:0]  released_count;
		logic [63:0] released_high;
		logic [63:0] released_low;
		logic        release_now;
		logic        continuous_resolved;
		logic        hold;
	} spc_result_t;

	// Hold decision with hysteresis
	function automatic logic hold_test(input logic cont, input logic held,
			input logic [6:0] v, input logic [6:0] thr);
		logic res;
		if (cont) begin
			res = held ? (v >= CONT_OFF) : (v >= CONT_ON);
		end else begin
			res = held ? ((8'(v) + BIN_HYST) >= 8'(thr)) : (v >= thr);
		end
		return res;
	endfunction

	// One xorshift32 step, zero seed replaced first
	function automatic logic [31:0] seed_step(input logic [31:0] cur);
		logic [31:0] s;
		s = (cur == 32'd0) ? SEED_FILL : cur;
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

endpackage

// ===== rtl/spc_pedal.sv =====
// Pedal unit: mode resolution, auto detect, hold hysteresis and noise trigger.
module spc_pedal (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [1:0]              func,
	input  logic [6:0]              value,
	input  logic [1:0]              sense_mode,
	input  logic [6:0]              binary_threshold,
	input  logic                    noise_enable,
	output spc_pkg::spc_evt_t       evt,
	output spc_pkg::spc_pedal_res_t res
);
	import spc_pkg::*;

	logic        hold_q;
	logic [6:0]  last_q;
	logic [6:0]  min_q;
	logic [6:0]  max_q;
	logic        auto_q;
	logic [31:0] rng_q;

	logic        is_pedal;
	logic        in_mid;
	logic [6:0]  min_nx;
	logic [6:0]  max_nx;
	logic        auto_nx;
	logic        cont_cur;
	logic        cont_nx;
	logic        hold_nx;
	logic [6:0]  delta;
	logic        fire;
	logic [31:0] seed_nx;

	// Resolve mode and update the mid-range spread
	always_comb begin
		is_pedal = (func == FUNC_PEDAL);
		in_mid   = (sense_mode == MODE_AUTO) && (value != 7'd0) && (value != PEDAL_MAX);
		min_nx   = (in_mid && (value < min_q)) ? value : min_q;
		max_nx   = (in_mid && (value > max_q)) ? value : max_q;
		auto_nx  = auto_q || (in_mid && (8'(max_nx) >= (8'(min_nx) + AUTO_SPREAD)));
		cont_cur = (sense_mode == MODE_AUTO) ? auto_q : (sense_mode == MODE_CONTINUOUS);
		cont_nx  = (sense_mode == MODE_AUTO) ? auto_nx : (sense_mode == MODE_CONTINUOUS);
		hold_nx  = hold_test(cont_nx, hold_q, value, binary_threshold);
	end

	// Noise trigger on hold edges or large moves
	always_comb begin
		delta   = (value > last_q) ? (value - last_q) : (last_q - value);
		fire    = is_pedal && noise_enable && (value != last_q) &&
			((hold_nx != hold_q) || (delta >= NOISE_MOVE));
		seed_nx = seed_step(rng_q);
	end

	// Drive the event result
	always_comb begin
		evt.hold_test = hold_test(cont_cur, hold_q, last_q, binary_threshold);
		evt.drop      = is_pedal && hold_q && !hold_nx;

		res.hold       = is_pedal ? hold_nx : hold_q;
		res.cont       = is_pedal ? cont_nx : cont_cur;
		res.last_pedal = last_q;
		res.fire       = fire;
		res.down       = fire && ((value > last_q) || (!hold_q && hold_nx));
		res.intensity  = fire ? delta : 7'd0;
		res.seed       = fire ? seed_nx : 32'd0;
	end

	// Advance pedal state on a pedal beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			last_q <= 7'd0;
			min_q  <= PEDAL_MAX;
			max_q  <= 7'd0;
			auto_q <= 1'b0;
			rng_q  <= 32'd0;
		end else if (en && is_pedal) begin
			hold_q <= hold_nx;
			last_q <= value;
			min_q  <= min_nx;
			max_q  <= max_nx;
			auto_q <= auto_nx;
			if (fire) begin
				rng_q <= seed_nx;
			end
		end
	end

endmodule

// ===== rtl/spc_marks.sv =====
// Note unit: sustained-note bitmap with a running count of marked notes.
`include "sustain_pedal_controller_core_defines.svh"

module spc_marks #(
	parameter int NOTE_COUNT = spc_pkg::SPC_NOTE_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [1:0]        func,
	input  logic [6:0]        note,
	input  spc_pkg::spc_evt_t evt,
	output logic              release_now,
	output logic [127:0]      released,
	output logic [6:0]        released_count,
	output logic              any_released
);
	import spc_pkg::*;

	localparam int NW = $clog2(NOTE_COUNT);
	localparam int CW = $clog2(NOTE_COUNT + 1);
	localparam logic [7:0] NOTE_LIM = 8'(NOTE_COUNT);

	logic [NOTE_COUNT-1:0] marks_q;
	logic [CW-1:0]         count_q;

	logic          in_range;
	logic [NW-1:0] idx;
	logic          mark_cur;
	logic          set_mark;
	logic          clr_mark;

	// Decode the note beat
	always_comb begin
		in_range    = (8'(note) < NOTE_LIM);
		idx         = note[NW-1:0];
		mark_cur    = in_range && marks_q[idx];
		set_mark    = (func == FUNC_NOTE_OFF) && in_range && evt.hold_test;
		clr_mark    = (func == FUNC_NOTE_ON) && in_range;
		release_now = (func == FUNC_NOTE_OFF) && in_range && !evt.hold_test;
	end

	// Report the notes freed by a pedal release
	always_comb begin
		released       = evt.drop ? 128'(marks_q) : 128'd0;
		released_count = !evt.drop ? 7'd0 :
			((count_q >= CW'(127)) ? 7'd127 : 7'(count_q));
		any_released   = evt.drop && (count_q != '0);
	end

	// Update the bitmap and its count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			count_q <= '0;
		end else if (en) begin
			if (evt.drop) begin
				marks_q <= '0;
				count_q <= '0;
			end else if (set_mark) begin
				marks_q[idx] <= 1'b1;
				if (!mark_cur) begin
					count_q <= count_q + CW'(1);
				end
			end else if (clr_mark) begin
				marks_q[idx] <= 1'b0;
				if (mark_cur) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	`SPC_ASSERT_NOW(a_count_tracks_marks, 1'b1, $countones(marks_q) == int'(count_q), "mark count out of step with bitmap")
	`SPC_ASSERT_NEXT(a_drop_clears_marks, en && evt.drop, marks_q == '0, "pedal release left notes marked")
	`SPC_ASSERT_NEXT(a_held_note_marked, en && set_mark && !evt.drop, marks_q[$past(idx)], "held note-off not marked")

endmodule

// ===== rtl/sustain_pedal_controller_core.sv =====
// Top level of the sustain pedal controller: input stage, units and result register.
//
// Channel  Dir  Handshake         Payload
// s_*      in   tvalid/tready     tuser: func; tdata: note, value
// m_*      out  tvalid/tready     tdata: one result per event
// cfg_*    in   cfg_we            cfg_index, cfg_data
//
// Events pass the input then the result register; one event per cycle while m_tready holds.
// The input register feeds the pedal and note units; their state updates as the result registers.
// Reset clears the note bitmap, pedal state and seed at once; no clearing pass.
// A stalled result holds the input register; s_tready drops only when both are full.
module sustain_pedal_controller_core #(
	parameter int NOTE_COUNT = spc_pkg::SPC_NOTE_COUNT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // [6:0] note, [13:7] value, [15:14] zero
	input  logic [1:0]   s_tuser,  // [1:0] func
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] hold, [1] continuous_resolved, [2] release_now, [66:3] released_low,
	// [130:67] released_high, [137:131] released_count, [144:138] damper_level,
	// [145] noise_fire, [146] noise_down, [153:147] noise_intensity,
	// [185:154] noise_seed, [191:186] zero
	output logic [191:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [6:0]   cfg_data
);
	import spc_pkg::*;

	logic [1:0] sense_mode_q;
	logic [6:0] binary_threshold_q;
	logic       noise_enable_q;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [6:0] note_s1;
	logic [6:0] value_s1;

	logic        out_valid_q;
	spc_result_t out_q;

	logic           advance;
	logic           accept;
	spc_evt_t       evt;
	spc_pedal_res_t ped;
	logic           release_now;
	logic [127:0]   released;
	logic [6:0]     released_count;
	logic           any_released;
	spc_result_t    res;

	// Handshake: move s1 on when the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_mode_q       <= RST_SENSE_MODE;
			binary_threshold_q <= RST_BINARY_THRESHOLD;
			noise_enable_q     <= RST_NOISE_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSE_MODE:       sense_mode_q       <= cfg_data[1:0];
				REG_BINARY_THRESHOLD: binary_threshold_q <= cfg_data;
				REG_NOISE_ENABLE:     noise_enable_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= s_tuser;
			note_s1  <= s_tdata[6:0];
			value_s1 <= s_tdata[13:7];
		end
	end

	spc_pedal u_pedal (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (advance),
		.func             (func_s1),
		.value            (value_s1),
		.sense_mode       (sense_mode_q),
		.binary_threshold (binary_threshold_q),
		.noise_enable     (noise_enable_q),
		.evt              (evt),
		.res              (ped)
	);

	spc_marks #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_marks (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.func           (func_s1),
		.note           (note_s1),
		.evt            (evt),
		.release_now    (release_now),
		.released       (released),
		.released_count (released_count),
		.any_released   (any_released)
	);

	// Assemble the result beat
	always_comb begin
		res.hold                = ped.hold;
		res.continuous_resolved = ped.cont;
		res.release_now         = release_now;
		res.released_low        = released[63:0];
		res.released_high       = released[127:64];
		res.released_count      = released_count;
		res.damper_level        = (release_now || any_released) ? ped.last_pedal : 7'd0;
		res.noise_fire          = ped.fire;
		res.noise_down          = ped.down;
		res.noise_intensity     = ped.intensity;
		res.noise_seed          = ped.seed;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 192'(out_q);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the sustain pedal controller core.
module testbench;
	import spc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] FUNC_IGNORED = 2'd3;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata   = '0;   // [6:0] note, [13:7] value, [15:14] zero
	logic [1:0]   s_tuser   = '0;   // [1:0] func
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [191:0] m_tdata;          // result fields from hold at bit 0 up to noise_seed
	logic         cfg_we    = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [6:0]   cfg_data  = '0;

	// Fixed expectation travelling with the current input beat
	logic beat_typed = 1'b0;
	logic beat_hold  = 1'b0;
	logic beat_cont  = 1'b0;
	logic beat_rel   = 1'b0;

	// Idle percentages for the two sides
	int sender_gap_pct = 30;
	int recv_stall_pct = 30;
	int stall_left     = 0;
	int mismatches     = 0;

	// Own copy of the pedal state and registers
	logic [127:0] held_notes = '0;
	logic         hold_q     = 1'b0;
	logic [6:0]   last_val   = '0;
	logic [6:0]   mid_lo     = PEDAL_MAX;
	logic [6:0]   mid_hi     = '0;
	logic         auto_cont  = 1'b0;
	logic [31:0]  rng_q      = '0;
	logic [1:0]   mode_q     = RST_SENSE_MODE;
	logic [6:0]   thr_q      = RST_BINARY_THRESHOLD;
	logic         noise_en_q = RST_NOISE_ENABLE;

	spc_result_t pending_results[$];

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] note;
		logic [6:0] value;
		logic       typed;
		logic       hold;
		logic       cont;
		logic       rel;
	} pedal_row_t;

	// Opening script under reset registers: auto mode, threshold 64, noise on
	pedal_row_t pedal_script [20] = '{
		'{FUNC_NOTE_OFF, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 1'b1}, // immediate release
		'{FUNC_PEDAL,    7'd0,   7'd127, 1'b1, 1'b1, 1'b0, 1'b0}, // full press
		'{FUNC_NOTE_OFF, 7'd0,   7'd0,   1'b1, 1'b1, 1'b0, 1'b0}, // held, lowest note
		'{FUNC_NOTE_OFF, 7'd127, 7'd0,   1'b1, 1'b1, 1'b0, 1'b0}, // held, highest note
		'{FUNC_NOTE_ON,  7'd127, 7'd0,   1'b1, 1'b1, 1'b0, 1'b0}, // note-on clears mark
		'{FUNC_NOTE_OFF, 7'd64,  7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd61,  1'b0, 1'b0, 1'b0, 1'b0}, // stays on hysteresis
		'{FUNC_PEDAL,    7'd0,   7'd60,  1'b0, 1'b0, 1'b0, 1'b0}, // drops, releases two
		'{FUNC_IGNORED,  7'd127, 7'd127, 1'b1, 1'b0, 1'b0, 1'b0}, // no state change
		'{FUNC_PEDAL,    7'd0,   7'd64,  1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd63,  1'b0, 1'b0, 1'b0, 1'b0}, // small move, no noise
		'{FUNC_NOTE_OFF, 7'd5,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd72,  1'b0, 1'b0, 1'b0, 1'b0}, // spread turns auto continuous
		'{FUNC_PEDAL,    7'd0,   7'd115, 1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_NOTE_OFF, 7'd127, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd105, 1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd104, 1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_NOTE_OFF, 7'd1,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_PEDAL,    7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{FUNC_NOTE_ON,  7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0}
	};

	sustain_pedal_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Gap length: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 8) begin
			return $urandom_range(10, 30);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic mode_is_continuous();
		if (mode_q == MODE_AUTO) begin
			return auto_cont;
		end
		return mode_q == MODE_CONTINUOUS;
	endfunction

	// Hysteresis decision against the held state
	function automatic logic pedal_holds(logic [6:0] v);
		int lim;
		if (mode_is_continuous()) begin
			return hold_q ? (v >= CONT_OFF) : (v >= CONT_ON);
		end
		lim = hold_q ? int'(thr_q) - int'(BIN_HYST) : int'(thr_q);
		return int'(v) >= lim;
	endfunction

	function automatic logic [31:0] next_noise_seed();
		logic [31:0] s;
		s = (rng_q == 32'd0) ? SEED_FILL : rng_q;
		s ^= s << 13;
		s ^= s >> 17;
		s ^= s << 5;
		rng_q = s;
		return s;
	endfunction

	// Advance the pedal state by one event and return its result beat
	function automatic spc_result_t predict_pedal_event(logic [1:0] func, logic [6:0] note,
			logic [6:0] value);
		spc_result_t res;
		logic        was_held;
		logic        pressed;
		logic        lifted;
		logic [6:0]  prev;
		logic [6:0]  delta;
		int          freed;
		res = '0;
		case (func)
			FUNC_NOTE_ON: begin
				held_notes[note] = 1'b0;
			end
			FUNC_NOTE_OFF: begin
				if (pedal_holds(last_val)) begin
					held_notes[note] = 1'b1;
				end else begin
					res.release_now  = 1'b1;
					res.damper_level = last_val;
				end
			end
			FUNC_PEDAL: begin
				// Track the mid-range spread in auto mode
				if (mode_q == MODE_AUTO && value != 7'd0 && value != PEDAL_MAX) begin
					if (value < mid_lo) mid_lo = value;
					if (value > mid_hi) mid_hi = value;
					if (int'(mid_hi) >= int'(mid_lo) + int'(AUTO_SPREAD)) auto_cont = 1'b1;
				end
				was_held = hold_q;
				prev     = last_val;
				last_val = value;
				hold_q   = pedal_holds(value);
				pressed  = !was_held && hold_q;
				lifted   = was_held && !hold_q;
				delta    = (value > prev) ? value - prev : prev - value;
				if (noise_en_q && value != prev && (pressed || lifted || delta >= NOISE_MOVE)) begin
					res.noise_fire      = 1'b1;
					res.noise_down      = (value > prev) || pressed;
					res.noise_intensity = delta;
					res.noise_seed      = next_noise_seed();
				end
				// Pedal up frees every sustained note
				if (lifted) begin
					freed = $countones(held_notes);
					res.released_low   = held_notes[63:0];
					res.released_high  = held_notes[127:64];
					res.released_count = 7'((freed > 127) ? 127 : freed);
					if (freed > 0) res.damper_level = prev;
					held_notes = '0;
				end
			end
			default: ;
		endcase
		res.hold                = hold_q;
		res.continuous_resolved = mode_is_continuous();
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic check_result(input spc_result_t got, input spc_result_t want);
		if (got.hold !== want.hold)
			report_mismatch("hold", got.hold, want.hold);
		if (got.continuous_resolved !== want.continuous_resolved)
			report_mismatch("continuous_resolved", got.continuous_resolved,
				want.continuous_resolved);
		if (got.release_now !== want.release_now)
			report_mismatch("release_now", got.release_now, want.release_now);
		if (got.released_low !== want.released_low)
			report_mismatch("released_low", got.released_low, want.released_low);
		if (got.released_high !== want.released_high)
			report_mismatch("released_high", got.released_high, want.released_high);
		if (got.released_count !== want.released_count)
			report_mismatch("released_count", got.released_count, want.released_count);
		if (got.damper_level !== want.damper_level)
			report_mismatch("damper_level", got.damper_level, want.damper_level);
		if (got.noise_fire !== want.noise_fire)
			report_mismatch("noise_fire", got.noise_fire, want.noise_fire);
		if (got.noise_down !== want.noise_down)
			report_mismatch("noise_down", got.noise_down, want.noise_down);
		if (got.noise_intensity !== want.noise_intensity)
			report_mismatch("noise_intensity", got.noise_intensity, want.noise_intensity);
		if (got.noise_seed !== want.noise_seed)
			report_mismatch("noise_seed", got.noise_seed, want.noise_seed);
	endtask

	// Receiver stalls, changed at the falling edge
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < recv_stall_pct) begin
			stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Sample both streams and the register port at the rising edge
	always @(posedge clk) begin : track_pedal_results
		spc_result_t got;
		spc_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SENSE_MODE:       mode_q     = cfg_data[1:0];
					REG_BINARY_THRESHOLD: thr_q      = cfg_data;
					REG_NOISE_ENABLE:     noise_en_q = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = spc_result_t'(m_tdata[$bits(spc_result_t)-1:0]);
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result beat", 64'd0, 64'd0);
				end else begin
					want = pending_results.pop_front();
					check_result(got, want);
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_pedal_event(s_tuser, s_tdata[6:0], s_tdata[13:7]);
				if (beat_typed) begin
					want.hold                = beat_hold;
					want.continuous_resolved = beat_cont;
					want.release_now         = beat_rel;
				end
				pending_results.insert(pending_results.size(), want);
			end
		end
	end

	// Present one event and hold it until the beat is taken
	task automatic send_event(input logic [1:0] func, input logic [6:0] note,
			input logic [6:0] value, input logic typed, input logic hold,
			input logic cont, input logic rel);
		int gap;
		gap = ($urandom_range(0, 99) < sender_gap_pct) ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid   = 1'b1;
		s_tuser    = func;
		s_tdata    = {2'b00, value, note};
		beat_typed = typed;
		beat_hold  = hold;
		beat_cont  = cont;
		beat_rel   = rel;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [1:0] func, input logic [6:0] note,
			input logic [6:0] value);
		send_event(func, note, value, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	// Wait until every result is back and the pipeline has emptied
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [6:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Random traffic, mostly press / notes / lift phrases
	task automatic run_random_events(input int count);
		int sent;
		int kind;
		int k;
		int v;
		logic [1:0] f;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				v = $urandom_range(0, 1) ? 127 - $urandom_range(0, 12) : $urandom_range(0, 127);
				send_plain(FUNC_PEDAL, 7'($urandom), 7'(v));
				sent++;
				k = $urandom_range(1, 8);
				repeat (k) begin
					f = ($urandom_range(0, 3) != 0) ? FUNC_NOTE_OFF : FUNC_NOTE_ON;
					send_plain(f, 7'($urandom), 7'($urandom));
					sent++;
				end
				v = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 127);
				send_plain(FUNC_PEDAL, 7'($urandom), 7'(v));
				sent++;
			end else if (kind < 75) begin
				// Hover around the engage and release levels
				repeat ($urandom_range(2, 5)) begin
					case ($urandom_range(0, 3))
						0: v = int'(thr_q);
						1: v = int'(thr_q) - int'(BIN_HYST);
						2: v = int'(CONT_ON);
						default: v = int'(CONT_OFF);
					endcase
					v = v + $urandom_range(0, 6) - 3;
					if (v < 0) v = 0;
					if (v > 127) v = 127;
					if ($urandom_range(0, 2) == 0) begin
						send_plain(FUNC_NOTE_OFF, 7'($urandom), 7'($urandom));
						sent++;
					end
					send_plain(FUNC_PEDAL, 7'($urandom), 7'(v));
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					f = 2'($urandom);
					send_plain(f, 7'($urandom), 7'($urandom));
					if (f != FUNC_IGNORED) sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [1:0] mode, input logic [6:0] thr,
			input logic noise, input int gap_pct, input int stall_pct, input int count);
		drain_results();
		write_register(REG_SENSE_MODE, {5'd0, mode});
		write_register(REG_BINARY_THRESHOLD, thr);
		write_register(REG_NOISE_ENABLE, {6'd0, noise});
		sender_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		run_random_events(count);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (pedal_script[i]) begin
			send_event(pedal_script[i].func, pedal_script[i].note, pedal_script[i].value,
				pedal_script[i].typed, pedal_script[i].hold, pedal_script[i].cont,
				pedal_script[i].rel);
		end

		// Sustain every note at once, then lift: count saturates
		send_plain(FUNC_PEDAL, 7'd0, PEDAL_MAX);
		for (int n = 0; n < 128; n++) begin
			send_plain(FUNC_NOTE_OFF, 7'(n), 7'($urandom));
		end
		send_plain(FUNC_PEDAL, 7'd0, 7'd0);

		run_random_events(65);
		run_phase(MODE_BINARY, 7'd127, 1'b1, 30, 30, 65);
		run_phase(MODE_CONTINUOUS, 7'd1, 1'b0, 0, 0, 65);
		run_phase(MODE_SPARE, 7'd0, 1'b1, 30, 30, 65);
		run_phase(MODE_AUTO, 7'($urandom_range(1, 127)), 1'b1, 40, 20, 65);
		run_phase(MODE_BINARY, 7'($urandom_range(1, 126)), 1'($urandom), 20, 40, 65);
		run_phase(MODE_CONTINUOUS, 7'd127, 1'b1, 0, 0, 65);
		run_phase(MODE_BINARY, 7'd4, 1'b1, 30, 30, 65);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sustain_pedal_controller_core.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_pedal.sv
rtl/spc_marks.sv
rtl/sustain_pedal_controller_core.sv
tb/testbench.sv
